[rtl/ket_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ket_pkg - shared definitions for the keyed entry table
// Table size, text widths, opcodes, the stored entry layout and the control
// group that drives the entry store.
// ----------------------------------------------------------------------------
package ket_pkg;

	localparam int SLOTS       = 64;
	localparam int KEY_BYTES   = 8;
	localparam int TITLE_BYTES = 8;
	localparam int IDX_W       = $clog2(SLOTS);

	// Keep only the low n bytes of a packed text word
	function automatic logic [63:0] byte_mask(input int n);
		logic [63:0] m;
		if (n >= 8) begin
			m = '1;
		end else begin
			m = (64'd1 << (8 * n)) - 64'd1;
		end
		return m;
	endfunction

	localparam logic [63:0] KEY_MASK   = byte_mask(KEY_BYTES);
	localparam logic [63:0] TITLE_MASK = byte_mask(TITLE_BYTES);

	typedef logic [1:0] opcode_t;

	localparam opcode_t OP_ADD    = 2'd0;
	localparam opcode_t OP_UPDATE = 2'd1;
	localparam opcode_t OP_DELETE = 2'd2;
	localparam opcode_t OP_SEARCH = 2'd3;

	typedef struct packed {
		logic [63:0]        title;
		logic [31:0]        price;
		logic signed [31:0] amount;
	} entry_t;

	typedef struct packed {
		logic             key_re;
		logic [IDX_W-1:0] key_raddr;
		logic             data_re;
		logic [IDX_W-1:0] data_raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
	} store_ctl_t;

endpackage

[rtl/ket_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ket_store - key and entry memories
// Two synchronous single-port-write, single-port-read memories with registered
// read data: one holds keys, the other title, price and quantity.
// ----------------------------------------------------------------------------
module ket_store import ket_pkg::*; (
	input  logic        clk,
	input  store_ctl_t  ctl,
	input  logic [63:0] wkey,
	input  entry_t      wentry,
	output logic [63:0] key_rd,
	output entry_t      entry_rd
);

	logic [63:0] key_mem [SLOTS];
	entry_t      entry_mem [SLOTS];

	// Key memory: write on fill or update, read during the scan
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			key_mem[ctl.waddr] <= wkey;
		end
		if (ctl.key_re) begin
			key_rd <= key_mem[ctl.key_raddr];
		end
	end

	// Entry memory: write on fill or update, read on a search hit
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			entry_mem[ctl.waddr] <= wentry;
		end
		if (ctl.data_re) begin
			entry_rd <= entry_mem[ctl.data_raddr];
		end
	end

endmodule

[rtl/keyed_entry_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_entry_table_top - associative key/value table
// Add, update, delete and search on a table of SLOTS entries. Each command
// scans the key memory for the lowest valid match and the lowest free slot,
// then writes back at most once and reports one result word.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Fields
// command   in         start & !busy          opcode key_word title_word
//                                             price_bits amount
// result    out        done (one cycle)       success hit_title hit_price
//                                             hit_amount
//
// A command that finds no key runs the key scan over all SLOTS entries, which
// reads one key memory entry per cycle; a match ends the scan early. A search
// hit adds the entry read in ST_RDATA, so a search hit in the last slot takes
// the longest.
// Busy stays high from acceptance until the cycle the result is strobed, and
// a new command may start in that strobe cycle. Reset clears all valid marks
// at once. The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module keyed_entry_table_top import ket_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [63:0]        key_word,
	input  logic [63:0]        title_word,
	input  logic [31:0]        price_bits,
	input  logic signed [31:0] amount,
	output logic               done,
	output logic               success,
	output logic [63:0]        hit_title,
	output logic [31:0]        hit_price,
	output logic signed [31:0] hit_amount
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FIN   = 3'd2;
	localparam logic [2:0] ST_RDATA = 3'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	logic [2:0]       state_q;
	opcode_t          op_q;
	logic [63:0]      key_q;
	entry_t           entry_q;
	logic [SLOTS-1:0] valid_q;

	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_on_q;
	logic             chk_on_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic             done_q;
	logic             success_q;
	entry_t           result_q;

	store_ctl_t       ctl;
	logic [63:0]      key_rd;
	entry_t           entry_rd;

	logic             match;
	logic             scan_end;
	logic             add_ok;
	logic             upd_ok;
	logic             del_ok;
	logic             srch_ok;

	ket_store u_store (
		.clk      (clk),
		.ctl      (ctl),
		.wkey     (key_q),
		.wentry   (entry_q),
		.key_rd   (key_rd),
		.entry_rd (entry_rd)
	);

	// Compare the key word that came back from memory
	assign match    = chk_on_s1 && valid_q[chk_idx_s1] && (key_rd == key_q);
	assign scan_end = chk_on_s1 && (match || (chk_idx_s1 == LAST_IDX));

	// Decide the write-back once the scan is over
	assign add_ok  = (op_q == OP_ADD) && !hit_q && free_q;
	assign upd_ok  = (op_q == OP_UPDATE) && hit_q;
	assign del_ok  = (op_q == OP_DELETE) && hit_q;
	assign srch_ok = (op_q == OP_SEARCH) && hit_q;

	// Drive the memories
	always_comb begin
		ctl            = '0;
		ctl.key_re     = (state_q == ST_SCAN) && rd_on_q;
		ctl.key_raddr  = rd_idx_q;
		ctl.data_re    = (state_q == ST_FIN) && srch_ok;
		ctl.data_raddr = hit_idx_q;
		ctl.we         = (state_q == ST_FIN) && (add_ok || upd_ok);
		ctl.waddr      = add_ok ? free_idx_q : hit_idx_q;
	end

	// Control: sequencer, scan pointers, valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			rd_on_q   <= 1'b0;
			chk_on_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						rd_on_q   <= 1'b1;
						chk_on_s1 <= 1'b0;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance the read pointer, stop after the last slot
					if (rd_on_q && (rd_idx_q == LAST_IDX)) begin
						rd_on_q <= 1'b0;
					end
					chk_on_s1 <= rd_on_q && !scan_end;
					// note the lowest free slot
					if (chk_on_s1 && !valid_q[chk_idx_s1] && !free_q) begin
						free_q <= 1'b1;
					end
					if (match) begin
						hit_q <= 1'b1;
					end
					if (scan_end) begin
						rd_on_q <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (add_ok) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					if (del_ok) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
					if (srch_ok) begin
						state_q <= ST_RDATA;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RDATA: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: command word, scan indices, result word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q          <= opcode;
					key_q         <= key_word & KEY_MASK;
					entry_q.title <= title_word & TITLE_MASK;
					entry_q.price <= price_bits;
					entry_q.amount <= amount;
					rd_idx_q      <= '0;
				end
			end
			ST_SCAN: begin
				if (rd_on_q && (rd_idx_q != LAST_IDX)) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				chk_idx_s1 <= rd_idx_q;
				if (chk_on_s1 && !valid_q[chk_idx_s1] && !free_q) begin
					free_idx_q <= chk_idx_s1;
				end
				if (match) begin
					hit_idx_q <= chk_idx_s1;
				end
			end
			ST_FIN: begin
				success_q <= add_ok || upd_ok || del_ok || srch_ok;
				result_q  <= '0;
			end
			ST_RDATA: begin
				success_q <= 1'b1;
				result_q  <= entry_rd;
			end
			default: begin
				success_q <= 1'b0;
			end
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign success    = success_q;
	assign hit_title  = result_q.title;
	assign hit_price  = result_q.price;
	assign hit_amount = result_q.amount;

endmodule
